FILE: rtl/core/lc2k_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lc2k_pkg;

  localparam int ADDR_BITS_DEF     = 16;
  localparam int NUM_REGISTERS_DEF = 8;

  localparam int WORD_W   = 32;
  localparam int OPC_W    = 3;
  localparam int OPC_LSB  = 22;
  localparam int REGA_LSB = 19;
  localparam int REGB_LSB = 16;
  localparam int DEST_LSB = 0;
  localparam int OFF_W    = 16;

  // opcodes
  localparam logic [OPC_W-1:0] OP_ADD  = 3'd0;
  localparam logic [OPC_W-1:0] OP_NAND = 3'd1;
  localparam logic [OPC_W-1:0] OP_LW   = 3'd2;
  localparam logic [OPC_W-1:0] OP_SW   = 3'd3;
  localparam logic [OPC_W-1:0] OP_BEQ  = 3'd4;
  localparam logic [OPC_W-1:0] OP_JALR = 3'd5;
  localparam logic [OPC_W-1:0] OP_HALT = 3'd6;
  localparam logic [OPC_W-1:0] OP_NOOP = 3'd7;

  // result status codes
  localparam logic [2:0] ST_LOADED   = 3'd0;
  localparam logic [2:0] ST_EXECUTED = 3'd1;
  localparam logic [2:0] ST_HALTED   = 3'd2;
  localparam logic [2:0] ST_PAST_END = 3'd3;
  localparam logic [2:0] ST_STOPPED  = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic do_load;
    logic do_stopped;
    logic do_past;
    logic fetch;
    logic decode;
    logic exec;
    logic mem_wb;
    logic out_load;
  } lc2k_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cmd_load;
    logic stopped;
    logic past_end;
    logic is_lw;
    logic out_free;
  } lc2k_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/lc2k_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lc2k_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] address;
  logic signed [31:0] data;

  modport source (output valid, output command, output address, output data, input ready);
  modport sink   (input valid, input command, input address, input data, output ready);
endinterface

interface lc2k_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] next_pc;
  logic [2:0]  opcode_done;
  logic        reg_written;
  logic [2:0]  reg_index;
  logic signed [31:0] reg_value;
  logic [31:0] executed_count;

  modport source (output valid, output status, output next_pc, output opcode_done,
                  output reg_written, output reg_index, output reg_value,
                  output executed_count, input ready);
  modport sink   (input valid, input status, input next_pc, input opcode_done,
                  input reg_written, input reg_index, input reg_value,
                  input executed_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lc2k_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lc2k_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lc2k_pkg::lc2k_sts_t sts,
  output lc2k_pkg::lc2k_cmd_t    cmd
);
  import lc2k_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_MEM   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.cmd_load) begin
          cmd.do_load = 1'b1;
          state_nxt   = S_OUT;
        end else if (sts.stopped) begin
          cmd.do_stopped = 1'b1;
          state_nxt      = S_OUT;
        end else if (sts.past_end) begin
          cmd.do_past = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          cmd.fetch = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.decode = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.is_lw ? S_MEM : S_OUT;
      end
      S_MEM: begin
        cmd.mem_wb = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded into an occupied output register");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CHECK))
    else $error("accepted transfer not followed by check");

  a_exec_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> (state_r == S_MEM || state_r == S_OUT))
    else $error("execute not followed by memory or output");

  a_check_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.do_load, cmd.do_stopped, cmd.do_past, cmd.fetch}))
    else $error("more than one check outcome at once");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/lc2k_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module lc2k_dpath #(
  parameter int ADDR_BITS     = lc2k_pkg::ADDR_BITS_DEF,
  parameter int NUM_REGISTERS = lc2k_pkg::NUM_REGISTERS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lc2k_pkg::lc2k_cmd_t cmd,
  output lc2k_pkg::lc2k_sts_t      sts,
  input  wire logic                in_command,
  input  wire logic [15:0]         in_address,
  input  wire logic [31:0]         in_data,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [2:0]               out_status,
  output logic [15:0]              out_next_pc,
  output logic [2:0]               out_opcode_done,
  output logic                     out_reg_written,
  output logic [2:0]               out_reg_index,
  output logic [31:0]              out_reg_value,
  output logic [31:0]              out_executed_count
);
  import lc2k_pkg::*;

  localparam int MEM_WORDS = 1 << ADDR_BITS;
  localparam int RIDX_W    = $clog2(NUM_REGISTERS);
  localparam logic [ADDR_BITS-1:0] ONE_A = {{(ADDR_BITS-1){1'b0}}, 1'b1};

  // latched item
  logic                 cmd_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [WORD_W-1:0]    data_r;

  // machine state
  logic [ADDR_BITS-1:0] pc_r;
  logic [ADDR_BITS:0]   end_r;
  logic                 stopped_r;
  logic [31:0]          count_r;

  logic [WORD_W-1:0]    mem [MEM_WORDS];
  logic [WORD_W-1:0]    mem_rdata_r;
  logic [WORD_W-1:0]    rf [NUM_REGISTERS];
  logic [NUM_REGISTERS-1:0] rf_valid_r;

  logic [WORD_W-1:0]    ir_r;
  logic [WORD_W-1:0]    ra_val_r;
  logic [WORD_W-1:0]    rb_val_r;

  // pending result
  logic [2:0]           res_status_r;
  logic [OPC_W-1:0]     res_opc_r;
  logic                 res_wr_r;
  logic [RIDX_W-1:0]    res_idx_r;
  logic [WORD_W-1:0]    res_val_r;

  logic                 out_valid_r;

  // decode
  logic [OPC_W-1:0]     opc;
  logic [RIDX_W-1:0]    ra_idx;
  logic [RIDX_W-1:0]    rb_idx;
  logic [RIDX_W-1:0]    rd_idx;
  logic [RIDX_W-1:0]    fa_idx;
  logic [RIDX_W-1:0]    fb_idx;
  logic [ADDR_BITS-1:0] off_a;
  logic [ADDR_BITS-1:0] pc_inc;
  logic [ADDR_BITS-1:0] ea;
  logic [ADDR_BITS-1:0] npc;
  logic [WORD_W-1:0]    alu;

  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [WORD_W-1:0]    mem_wdata;
  logic                 rf_we;
  logic [RIDX_W-1:0]    rf_waddr;
  logic [WORD_W-1:0]    rf_wdata;
  logic                 out_free;

  assign opc    = ir_r[OPC_LSB +: OPC_W];
  assign ra_idx = ir_r[REGA_LSB +: RIDX_W];
  assign rb_idx = ir_r[REGB_LSB +: RIDX_W];
  assign rd_idx = ir_r[DEST_LSB +: RIDX_W];
  assign fa_idx = mem_rdata_r[REGA_LSB +: RIDX_W];
  assign fb_idx = mem_rdata_r[REGB_LSB +: RIDX_W];
  assign off_a  = ir_r[ADDR_BITS-1:0];
  assign pc_inc = pc_r + ONE_A;
  assign ea     = ra_val_r[ADDR_BITS-1:0] + off_a;

  always_comb begin
    npc = pc_inc;
    alu = ra_val_r + rb_val_r;
    case (opc)
      OP_NAND: alu = ~(ra_val_r & rb_val_r);
      OP_BEQ: begin
        if (ra_val_r == rb_val_r) begin
          npc = pc_inc + off_a;
        end
      end
      // regB is written first, so equal fields continue at pc+1
      OP_JALR: npc = (ra_idx == rb_idx) ? pc_inc : ra_val_r[ADDR_BITS-1:0];
      default: ;
    endcase
  end

  assign mem_we    = cmd.do_load | (cmd.exec & (opc == OP_SW));
  assign mem_addr  = cmd.exec ? ea : (cmd.do_load ? addr_r : pc_r);
  assign mem_wdata = cmd.do_load ? data_r : rb_val_r;

  assign rf_we    = cmd.mem_wb |
                    (cmd.exec & (opc == OP_ADD || opc == OP_NAND || opc == OP_JALR));
  assign rf_waddr = (cmd.mem_wb || opc == OP_JALR || opc == OP_LW) ? rb_idx : rd_idx;
  assign rf_wdata = cmd.mem_wb ? mem_rdata_r :
                    ((opc == OP_JALR) ? WORD_W'(pc_inc) : alu);

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    sts          = '0;
    sts.cmd_load = !cmd_r;
    sts.stopped  = stopped_r;
    sts.past_end = ({1'b0, pc_r} >= end_r);
    sts.is_lw    = (opc == OP_LW);
    sts.out_free = out_free;
  end

  // word memory, single port with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_addr];
  end

  // register file, two registered read ports, invalid entries read zero
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_waddr] <= rf_wdata;
    end
    if (cmd.decode) begin
      ir_r     <= mem_rdata_r;
      ra_val_r <= rf_valid_r[fa_idx] ? rf[fa_idx] : '0;
      rb_val_r <= rf_valid_r[fb_idx] ? rf[fb_idx] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_valid_r <= '0;
    end else if (rf_we) begin
      rf_valid_r[rf_waddr] <= 1'b1;
    end
  end

  // machine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= '0;
      end_r     <= '0;
      stopped_r <= 1'b0;
      count_r   <= '0;
    end else begin
      if (mem_we && ({1'b0, mem_addr} >= end_r)) begin
        end_r <= {1'b0, mem_addr} + {{ADDR_BITS{1'b0}}, 1'b1};
      end
      if (cmd.do_past || (cmd.exec && opc == OP_HALT)) begin
        stopped_r <= 1'b1;
      end
      if (cmd.exec) begin
        pc_r    <= npc;
        count_r <= count_r + 32'd1;
      end
    end
  end

  // item latch and pending result
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r  <= in_command;
      addr_r <= in_address[ADDR_BITS-1:0];
      data_r <= in_data;
    end
    if (cmd.do_load || cmd.do_stopped || cmd.do_past) begin
      res_status_r <= cmd.do_load ? ST_LOADED : (cmd.do_past ? ST_PAST_END : ST_STOPPED);
      res_opc_r    <= '0;
      res_wr_r     <= 1'b0;
      res_idx_r    <= '0;
      res_val_r    <= '0;
    end
    if (cmd.exec) begin
      res_status_r <= (opc == OP_HALT) ? ST_HALTED : ST_EXECUTED;
      res_opc_r    <= opc;
      res_wr_r     <= rf_we || (opc == OP_LW);
      res_idx_r    <= (rf_we || opc == OP_LW) ? rf_waddr : '0;
      res_val_r    <= rf_we ? rf_wdata : '0;
    end
    if (cmd.mem_wb) begin
      res_val_r <= mem_rdata_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status         <= res_status_r;
      out_next_pc        <= 16'(pc_r);
      out_opcode_done    <= res_opc_r;
      out_reg_written    <= res_wr_r;
      out_reg_index      <= 3'(res_idx_r);
      out_reg_value      <= res_val_r;
      out_executed_count <= count_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/core/lc2k_instruction_core.sv
`timescale 1ns / 1ps
`default_nettype none

// eight-opcode word machine with one unified word memory
// in_chan carries commands: command 0 stores data at address and moves the
// program end past it, command 1 executes the instruction at the pc
// out_chan returns exactly one result per command: status, pc after the
// command, opcode done, register write and the running instruction count
// a transfer takes place on a clock edge with valid and ready both high
// a load, or a step that does not execute, goes from check to output; a step
// goes check, fetch, execute, output, with memory before output for lw;
// the phases are set by the single-port memory (fetch and data access share
// it) and the registered register-file read, walked by the controller one
// phase a cycle, waiting in output while the output register is occupied
// a new command is taken while the previous result waits in the output
// register; when the receiver stalls the next result is held inside until
// the output register frees, and no further command is taken meanwhile
// reset (rst_n low, synchronous) clears pc, program end, stop flag, count
// and the register-file valid bits; memory words are undefined until loaded
module lc2k_instruction_core #(
  parameter int ADDR_BITS     = lc2k_pkg::ADDR_BITS_DEF,
  parameter int NUM_REGISTERS = lc2k_pkg::NUM_REGISTERS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lc2k_in_if.sink   in_chan,
  lc2k_out_if.source out_chan
);
  import lc2k_pkg::*;

  lc2k_cmd_t cmd;
  lc2k_sts_t sts;
  logic      in_ready;

  // sequencer: check, fetch, execute, memory, output
  lc2k_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_chan.ready = in_ready;

  // registers, memory, alu and output register
  lc2k_dpath #(
    .ADDR_BITS     (ADDR_BITS),
    .NUM_REGISTERS (NUM_REGISTERS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_command         (in_chan.command),
    .in_address         (in_chan.address),
    .in_data            (in_chan.data),
    .out_ready          (out_chan.ready),
    .out_valid          (out_chan.valid),
    .out_status         (out_chan.status),
    .out_next_pc        (out_chan.next_pc),
    .out_opcode_done    (out_chan.opcode_done),
    .out_reg_written    (out_chan.reg_written),
    .out_reg_index      (out_chan.reg_index),
    .out_reg_value      (out_chan.reg_value),
    .out_executed_count (out_chan.executed_count)
  );

endmodule

`default_nettype wire

FILE: sim/lc2k_instruction_core_test.sv
`timescale 1ns / 1ps

module lc2k_instruction_core_test;
  import lc2k_pkg::*;

  localparam int          ADDR_BITS    = ADDR_BITS_DEF;
  localparam logic [15:0] ADDR_MASK    = 16'((32'd1 << ADDR_BITS) - 1);
  localparam logic [16:0] END_TOP      = 17'(32'd1 << ADDR_BITS);
  localparam logic        CMD_LOAD     = 1'b0;
  localparam logic        CMD_STEP     = 1'b1;
  localparam int          STALL_CYCLES = 120;
  localparam int          MAX_REPORTS  = 100;

  // one result as the block reports it
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] next_pc;
    logic [2:0]  opcode_done;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [31:0] reg_value;
    logic [31:0] executed_count;
  } machine_result_t;

  logic clk = 1'b0;
  logic rst_n;

  always #4 clk = ~clk;

  lc2k_in_if  in_chan ();
  lc2k_out_if out_chan ();

  lc2k_instruction_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // machine state as the predictor sees it
  logic [31:0] core_regs [NUM_REGISTERS_DEF];
  logic [31:0] core_mem [int unsigned];
  logic [15:0] core_pc;
  logic [16:0] core_end;
  logic        core_stopped;
  logic [31:0] core_count;

  machine_result_t pending_results [$];

  int   items_sent;
  int   mismatch_count;
  bit   src_idling;
  logic sink_idling;
  logic sink_stall;
  bit   top_end_run;

  // gap lengths: mostly short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    else if (roll < 96) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] encode(input logic [2:0] op, input logic [2:0] ra,
                                         input logic [2:0] rb, input logic [15:0] off);
    return {7'd0, op, ra, rb, off};
  endfunction

  // data address of lw and sw: regA plus the sign-extended offset, wrapped
  function automatic logic [15:0] effective_address(input logic [31:0] ins);
    logic [31:0] base;
    base = core_regs[ins[REGA_LSB +: 3]];
    return 16'(base + {{16{ins[15]}}, ins[15:0]}) & ADDR_MASK;
  endfunction

  function automatic void extend_end(input logic [15:0] addr);
    if ({1'b0, addr} >= core_end) core_end = {1'b0, addr} + 17'd1;
  endfunction

  // applies one command to the machine state and returns what the block must report
  function automatic machine_result_t execute_command(input logic cmd, input logic [15:0] addr,
                                                      input logic [31:0] word);
    machine_result_t res;
    logic [31:0] ins;
    logic [31:0] off;
    logic [31:0] va;
    logic [31:0] vb;
    logic [15:0] npc;
    logic [15:0] ea;
    logic [2:0]  ra;
    logic [2:0]  rb;
    logic [2:0]  rd;
    res = '0;
    if (cmd == CMD_LOAD) begin
      ea = addr & ADDR_MASK;
      core_mem[ea] = word;
      extend_end(ea);
      res.status = ST_LOADED;
    end else if (core_stopped) begin
      res.status = ST_STOPPED;
    end else if ({1'b0, core_pc} >= core_end) begin
      core_stopped = 1'b1;
      res.status = ST_PAST_END;
    end else begin
      ins = core_mem.exists(core_pc) ? core_mem[core_pc] : 32'd0;
      ra  = ins[REGA_LSB +: 3];
      rb  = ins[REGB_LSB +: 3];
      rd  = ins[DEST_LSB +: 3];
      off = {{16{ins[15]}}, ins[15:0]};
      va  = core_regs[ra];
      vb  = core_regs[rb];
      ea  = effective_address(ins);
      npc = (core_pc + 16'd1) & ADDR_MASK;
      res.opcode_done = ins[OPC_LSB +: OPC_W];
      res.status = ST_EXECUTED;
      core_count = core_count + 32'd1;
      case (res.opcode_done)
        OP_ADD: begin
          res.reg_written = 1'b1;
          res.reg_index   = rd;
          res.reg_value   = va + vb;
        end
        OP_NAND: begin
          res.reg_written = 1'b1;
          res.reg_index   = rd;
          res.reg_value   = ~(va & vb);
        end
        OP_LW: begin
          res.reg_written = 1'b1;
          res.reg_index   = rb;
          res.reg_value   = core_mem.exists(ea) ? core_mem[ea] : 32'd0;
        end
        OP_SW: begin
          core_mem[ea] = vb;
          extend_end(ea);
        end
        OP_BEQ: begin
          if (va == vb) npc = 16'(core_pc + 16'd1 + off[15:0]) & ADDR_MASK;
        end
        OP_JALR: begin
          // link first, so regA equal to regB lands on pc+1
          core_regs[rb]   = {16'd0, npc};
          npc             = core_regs[ra][15:0] & ADDR_MASK;
          res.reg_written = 1'b1;
          res.reg_index   = rb;
          res.reg_value   = core_regs[rb];
        end
        OP_HALT: begin
          core_stopped = 1'b1;
          res.status   = ST_HALTED;
        end
        default: ;
      endcase
      if (res.reg_written) core_regs[res.reg_index] = res.reg_value;
      core_pc = npc;
    end
    res.next_pc        = core_pc;
    res.executed_count = core_count;
    return res;
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return $urandom_range(0, 16);
      default: return $urandom;
    endcase
  endfunction

  // any opcode but halt, offsets mostly short so branches stay near the code
  function automatic logic [31:0] random_instruction();
    logic [31:0] ins;
    logic [2:0]  op;
    ins = $urandom;
    do op = 3'($urandom_range(0, 7)); while (op == OP_HALT);
    ins[OPC_LSB +: OPC_W] = op;
    if ($urandom_range(0, 2) != 0) ins[15:0] = 16'(int'($urandom_range(0, 8)) - 4);
    return ins;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_REPORTS)
      $display("mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
    mismatch_count++;
  endtask

  // one input transfer; valid stays high unless a gap follows
  task automatic send_item(input logic cmd, input logic [15:0] addr, input logic [31:0] word);
    int gap;
    if (src_idling && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.command <= cmd;
    in_chan.address <= addr;
    in_chan.data    <= word;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    pending_results.push_back(execute_command(cmd, addr, word));
    items_sent++;
  endtask

  task automatic send_load(input logic [15:0] addr, input logic [31:0] word);
    send_item(CMD_LOAD, addr, word);
  endtask

  // address and data are don't-care on a step, so they are left random
  task automatic send_step();
    send_item(CMD_STEP, 16'($urandom), $urandom);
  endtask

  // step without stopping: no fetch past the end, no halt, no read of an unloaded word
  task automatic step_instruction();
    logic [31:0] ins;
    logic [15:0] ea;
    if ({1'b0, core_pc} >= core_end || !core_mem.exists(core_pc) ||
        core_mem[core_pc][OPC_LSB +: OPC_W] == OP_HALT)
      send_load(core_pc, random_instruction());
    ins = core_mem[core_pc];
    ea  = effective_address(ins);
    if (ins[OPC_LSB +: OPC_W] == OP_LW && !core_mem.exists(ea)) send_load(ea, random_word());
    send_step();
  endtask

  // mostly a short program loaded at the pc and run, sometimes a stray word or step
  task automatic run_program_block();
    int len;
    if ($urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 1) == 0) send_load(16'($urandom), $urandom);
      else step_instruction();
    end else begin
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++)
        send_load((core_pc + 16'(k)) & ADDR_MASK, random_instruction());
      repeat (len + $urandom_range(0, 2)) step_instruction();
    end
  endtask

  task automatic wait_for_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // every opcode but halt, word extremes, add overflow, store past the end, both branch outcomes,
  // jalr linking into its own target register
  task automatic test_directed_program();
    src_idling = 1'b0;
    sink_idling <= 1'b0;
    // lw pulls the largest and smallest words into r1 and r2
    send_load(16'd0,  encode(OP_LW, 3'd0, 3'd1, 16'd16));
    send_load(16'd16, 32'h7fff_ffff);
    send_load(16'd1,  encode(OP_LW, 3'd0, 3'd2, 16'd17));
    send_load(16'd17, 32'h8000_0000);
    // add goes to dest r3, not to regA; nand of all ones gives zero in r4
    send_load(16'd2,  encode(OP_ADD, 3'd1, 3'd2, 16'd3));
    send_load(16'd3,  encode(OP_NAND, 3'd3, 3'd3, 16'd4));
    // negative base plus offset lands well past the program end
    send_load(16'd4,  encode(OP_SW, 3'd3, 3'd2, 16'h0101));
    // taken branch over two unloaded words
    send_load(16'd5,  encode(OP_BEQ, 3'd0, 3'd4, 16'd2));
    send_load(16'd8,  encode(OP_JALR, 3'd5, 3'd5, 16'd0));
    // overflowing add, then a branch that is not taken with a negative offset
    send_load(16'd9,  encode(OP_ADD, 3'd1, 3'd1, 16'd6));
    send_load(16'd10, encode(OP_BEQ, 3'd1, 3'd0, 16'hfffc));
    // noop with every bit set
    send_load(16'd11, 32'hffff_ffff);
    repeat (10) send_step();
    // top address pushes the program end to its limit, done in half the runs only
    if (top_end_run) send_load(ADDR_MASK, random_word());
    wait_for_results();
  endtask

  task automatic test_random_programs();
    src_idling = 1'b1;
    sink_idling <= 1'b1;
    while (items_sent < 800) run_program_block();
    wait_for_results();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_backpressure();
    src_idling = 1'b0;
    sink_idling <= 1'b0;
    fork
      begin
        sink_stall <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        sink_stall <= 1'b0;
      end
    join_none
    repeat (12) run_program_block();
    wait_for_results();
  endtask

  // back-to-back transfers from the sender, receiver idling and then not
  task automatic test_unbroken_stream();
    src_idling = 1'b0;
    sink_idling <= 1'b1;
    while (items_sent < 980) run_program_block();
    sink_idling <= 1'b0;
    while (items_sent < 1130) run_program_block();
    wait_for_results();
  endtask

  // stop by halt or by running past the end, then loads and steps on a stopped machine
  task automatic test_stop_and_after();
    logic [16:0] limit;
    logic [31:0] ins;
    src_idling = 1'b1;
    sink_idling <= 1'b1;
    limit = ({1'b0, core_pc} < core_end) ? core_end : {1'b0, core_pc} + 17'd1;
    ins = $urandom;
    if (limit == END_TOP || $urandom_range(0, 1) == 0) begin
      ins[OPC_LSB +: OPC_W] = OP_HALT;
      send_load(core_pc, ins);
      send_step();
    end else begin
      // always-taken branch onto the program end, then the fetch there stops the machine
      ins[OPC_LSB +: OPC_W] = OP_BEQ;
      ins[REGA_LSB +: 3]    = ins[REGB_LSB +: 3];
      ins[15:0]             = limit[15:0] - (core_pc + 16'd1);
      send_load(core_pc, ins);
      send_step();
      send_step();
    end
    // a load is still taken but does not restart the machine
    send_load(core_pc, encode(OP_NOOP, 3'd0, 3'd0, 16'd0));
    repeat (6) begin
      if ($urandom_range(0, 2) == 0) send_load(16'($urandom), $urandom);
      else send_step();
    end
    wait_for_results();
  endtask

  // receiver side: random hold-offs, forced low during a pressure stretch
  initial begin : result_sink
    int gap_left;
    out_chan.ready <= 1'b0;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (sink_stall === 1'b1) begin
        out_chan.ready <= 1'b0;
      end else if (gap_left != 0) begin
        out_chan.ready <= 1'b0;
        gap_left--;
      end else if (sink_idling === 1'b1 && $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        gap_left = pick_gap() - 1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // each result transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    machine_result_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'd0, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_chan.status !== want.status)
          report_mismatch("status", 32'(out_chan.status), 32'(want.status));
        if (out_chan.next_pc !== want.next_pc)
          report_mismatch("next_pc", 32'(out_chan.next_pc), 32'(want.next_pc));
        if (out_chan.opcode_done !== want.opcode_done)
          report_mismatch("opcode_done", 32'(out_chan.opcode_done), 32'(want.opcode_done));
        if (out_chan.reg_written !== want.reg_written)
          report_mismatch("reg_written", 32'(out_chan.reg_written), 32'(want.reg_written));
        if (out_chan.reg_index !== want.reg_index)
          report_mismatch("reg_index", 32'(out_chan.reg_index), 32'(want.reg_index));
        if (out_chan.reg_value !== want.reg_value)
          report_mismatch("reg_value", out_chan.reg_value, want.reg_value);
        if (out_chan.executed_count !== want.executed_count)
          report_mismatch("executed_count", out_chan.executed_count, want.executed_count);
      end
    end
  end

  initial begin : watchdog
    #(20_000_000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : test_sequence
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.command <= CMD_LOAD;
    in_chan.address <= 16'd0;
    in_chan.data    <= 32'd0;
    sink_stall      <= 1'b0;
    sink_idling     <= 1'b0;
    src_idling      = 1'b0;
    items_sent      = 0;
    mismatch_count  = 0;
    foreach (core_regs[i]) core_regs[i] = 32'd0;
    core_pc      = 16'd0;
    core_end     = 17'd0;
    core_stopped = 1'b0;
    core_count   = 32'd0;
    top_end_run  = ($urandom_range(0, 1) == 1);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_program();
    test_random_programs();
    test_output_backpressure();
    test_unbroken_stream();
    test_stop_and_after();

    // let any stray result show up before the verdict
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/lc2k_pkg.sv
rtl/core/lc2k_if.sv
rtl/core/lc2k_ctrl.sv
rtl/core/lc2k_dpath.sv
rtl/core/lc2k_instruction_core.sv
sim/lc2k_instruction_core_test.sv
